// ===== src/ssms_pkg.sv =====
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared types and constants for the streaming sum / mean / deviation block.
// ----------------------------------------------------------------------------
package ssms_pkg;

	localparam int MAX_COUNT = 65536;
	localparam int CNT_W     = 17;
	localparam int SUM_W     = 32;
	localparam int SQS_W     = 47;
	localparam int RES_W     = 48;
	localparam int DDOF_W    = 16;

	localparam logic [1:0] OP_SUM  = 2'd0;
	localparam logic [1:0] OP_MEAN = 2'd1;
	localparam logic [1:0] OP_STD  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DDOF = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic CFG_OPERATION = 1'b0;
	localparam logic CFG_DOF       = 1'b1;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic [1:0]              status;
	} out_t;

	typedef struct packed {
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] sum;
		logic [SQS_W-1:0]        sumsq;
		logic                    ovf;
	} job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DEC,
		BK_MUL0,
		BK_MUL1,
		BK_ADD,
		BK_SUB,
		BK_DIV,
		BK_MEAN,
		BK_SQRT,
		BK_ROOT,
		BK_FIN
	} bk_state_t;

endpackage

// ===== src/stream_sum_mean_std.sv =====
// ----------------------------------------------------------------------------
// stream_sum_mean_std
// Streaming sum, mean or standard deviation of signed 16-bit sample sets.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle through a two-stage squaring and
// accumulation path; the transfer carrying last closes the set and its
// totals enter a two-entry queue. An evaluation sequencer drains the queue:
// the sum is scaled directly, the mean takes a 48-step long division and
// the deviation takes products, a 96-step long division and a 48-step
// square root. Intake stalls only when two closed sets are waiting.
// Results are Q31.16; status flags too many samples or a count not above
// the ddof register.
module stream_sum_mean_std (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ssms_pkg::DDOF_W-1:0]  cfg_wdata,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  ssms_pkg::in_t                item,
	output logic                         res_valid,
	input  logic                         res_ready,
	output ssms_pkg::out_t               res
);
	import ssms_pkg::*;

	logic [1:0]        op_q;
	logic [DDOF_W-1:0] ddof_q;
	logic              push, pop, full, empty;
	job_t              job_in, job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_SUM;
			ddof_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OPERATION: op_q   <= cfg_wdata[1:0];
				CFG_DOF:       ddof_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ssms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.job_push   (push),
		.job        (job_in),
		.q_full     (full)
	);

	ssms_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.full    (full),
		.empty   (empty)
	);

	ssms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.job       (job_out),
		.pop       (pop),
		.op        (op_q),
		.ddof      (ddof_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ===== src/ssms_front.sv =====
// ----------------------------------------------------------------------------
// ssms_front
// Sample intake: squares each sample, accumulates count, sum and sum of
// squares, and hands the totals of a finished set to the job queue.
// ----------------------------------------------------------------------------
module ssms_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  ssms_pkg::in_t item,
	output logic          job_push,
	output ssms_pkg::job_t job,
	input  logic          q_full
);
	import ssms_pkg::*;

	logic                    valid_s1, valid_s2;
	logic signed [15:0]      sample_s1, sample_s2;
	logic                    last_s1, last_s2;
	logic [30:0]             sq_s2;
	logic signed [31:0]      prod_s1;
	logic                    advance;
	logic [CNT_W-1:0]        cnt_q, cnt_n;
	logic signed [SUM_W-1:0] sum_q, sum_n;
	logic [SQS_W-1:0]        sumsq_q, sumsq_n;
	logic                    ovf_q, ovf_n, at_max;

	assign advance    = !(valid_s2 && last_s2 && q_full);
	assign item_ready = advance;
	assign prod_s1    = sample_s1 * sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= item.sample;
			last_s1   <= item.last;
			sample_s2 <= sample_s1;
			last_s2   <= last_s1;
			sq_s2     <= prod_s1[30:0];
		end
	end

	always_comb begin
		at_max  = (cnt_q == CNT_W'(MAX_COUNT));
		cnt_n   = at_max ? cnt_q : cnt_q + CNT_W'(1);
		sum_n   = at_max ? sum_q : sum_q + {{(SUM_W-16){sample_s2[15]}}, sample_s2};
		sumsq_n = at_max ? sumsq_q : sumsq_q + {{(SQS_W-31){1'b0}}, sq_s2};
		ovf_n   = ovf_q | at_max;
	end

	assign job_push = valid_s2 && last_s2 && !q_full;
	assign job      = '{count: cnt_n, sum: sum_n, sumsq: sumsq_n, ovf: ovf_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else if (valid_s2 && advance) begin
			if (last_s2) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				cnt_q   <= cnt_n;
				sum_q   <= sum_n;
				sumsq_q <= sumsq_n;
				ovf_q   <= ovf_n;
			end
		end
	end

endmodule

// ===== src/ssms_queue.sv =====
// ----------------------------------------------------------------------------
// ssms_queue
// Two-entry queue of finished set totals between intake and evaluation.
// ----------------------------------------------------------------------------
module ssms_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ssms_pkg::job_t job_in,
	input  logic           pop,
	output ssms_pkg::job_t job_out,
	output logic           full,
	output logic           empty
);
	import ssms_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full    = (fill_q == 2'd2);
	assign empty   = (fill_q == 2'd0);
	assign job_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== src/ssms_back.sv =====
// ----------------------------------------------------------------------------
// ssms_back
// Set evaluation: status checks, scaled sum, mean by long division, and
// deviation by products, long division and a digit-by-digit square root.
// ----------------------------------------------------------------------------
module ssms_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  ssms_pkg::job_t        job,
	output logic                  pop,
	input  logic [1:0]            op,
	input  logic [ssms_pkg::DDOF_W-1:0] ddof,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ssms_pkg::out_t        res
);
	import ssms_pkg::*;

	bk_state_t               state_q, state_n;
	logic                    res_load, step_last;

	logic [CNT_W-1:0]        n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQS_W-1:0]        sumsq_q;
	logic                    ovf_q;
	logic [31:0]             mag_q;
	logic [48:0]             prod_a_q;
	logic [31:0]             prod_b_q;
	logic [63:0]             sqm_q, nsq_q;
	logic [32:0]             den_q;
	logic [95:0]             d_q;
	logic [32:0]             rem_q;
	logic [6:0]              cnt_q;
	logic [47:0]             root_q;
	logic [49:0]             srem_q;
	logic [RES_W-1:0]        res_w_q;
	logic [1:0]              status_w_q;
	logic                    res_valid_q;
	out_t                    res_q;

	logic [CNT_W-1:0]        n_sub;
	logic [33:0]             den_full;
	logic [33:0]             rem_sh;
	logic                    div_ge;
	logic [51:0]             srem_sh;
	logic [51:0]             trial;
	logic                    sq_ge;
	logic [47:0]             mean_up;
	logic [63:0]             spread;

	assign n_sub    = n_q - {1'b0, ddof};
	assign den_full = n_q * n_sub;
	assign rem_sh   = {rem_q, d_q[95]};
	assign div_ge   = (rem_sh >= {1'b0, den_q});
	assign srem_sh  = {srem_q, d_q[95:94]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign sq_ge    = (srem_sh >= trial);
	assign mean_up  = d_q[47:0] + {47'd0, (rem_q != '0)};
	assign spread   = nsq_q - sqm_q;
	assign step_last = (cnt_q == 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		pop      = 1'b0;
		res_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_n = BK_DEC;
				end
			end
			BK_DEC: begin
				if (ovf_q || n_q <= {1'b0, ddof}) begin
					state_n = BK_FIN;
				end else begin
					case (op)
						OP_MEAN: state_n = BK_DIV;
						OP_STD:  state_n = BK_MUL0;
						default: state_n = BK_FIN;
					endcase
				end
			end
			BK_MUL0: state_n = BK_MUL1;
			BK_MUL1: state_n = BK_ADD;
			BK_ADD:  state_n = BK_SUB;
			BK_SUB:  state_n = BK_DIV;
			BK_DIV: begin
				if (step_last) begin
					state_n = (op == OP_STD) ? BK_SQRT : BK_MEAN;
				end
			end
			BK_MEAN: state_n = BK_FIN;
			BK_SQRT: begin
				if (step_last) begin
					state_n = BK_ROOT;
				end
			end
			BK_ROOT: state_n = BK_FIN;
			BK_FIN: begin
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_n  = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				n_q     <= job.count;
				sum_q   <= job.sum;
				sumsq_q <= job.sumsq;
				ovf_q   <= job.ovf;
				mag_q   <= job.sum[SUM_W-1] ? 32'(-job.sum) : 32'(job.sum);
			end
			BK_DEC: begin
				res_w_q    <= '0;
				status_w_q <= ST_OK;
				rem_q      <= '0;
				den_q      <= {16'd0, n_q};
				d_q        <= {mag_q, 64'd0};
				cnt_q      <= 7'd48;
				if (ovf_q) begin
					status_w_q <= ST_OVF;
				end else if (n_q <= {1'b0, ddof}) begin
					status_w_q <= ST_DDOF;
				end else if (op == OP_SUM) begin
					res_w_q <= {sum_q, 16'd0};
				end
			end
			BK_MUL0: begin
				prod_a_q <= n_q * sumsq_q[31:0];
				den_q    <= den_full[32:0];
			end
			BK_MUL1: begin
				prod_b_q <= n_q * sumsq_q[46:32];
				sqm_q    <= mag_q * mag_q;
			end
			BK_ADD: begin
				nsq_q <= {prod_b_q, 32'd0} + {15'd0, prod_a_q};
			end
			BK_SUB: begin
				d_q   <= {spread, 32'd0};
				rem_q <= '0;
				cnt_q <= 7'd96;
			end
			BK_DIV: begin
				rem_q <= div_ge ? rem_sh[32:0] - den_q : rem_sh[32:0];
				d_q   <= {d_q[94:0], div_ge};
				cnt_q <= step_last ? 7'd48 : cnt_q - 7'd1;
				srem_q <= '0;
				root_q <= '0;
			end
			BK_MEAN: begin
				res_w_q <= sum_q[SUM_W-1] ? -mean_up : d_q[47:0];
			end
			BK_SQRT: begin
				srem_q <= sq_ge ? 50'(srem_sh - trial) : srem_sh[49:0];
				root_q <= {root_q[46:0], sq_ge};
				d_q    <= {d_q[93:0], 2'b00};
				cnt_q  <= cnt_q - 7'd1;
			end
			BK_ROOT: begin
				res_w_q <= root_q;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_q <= '{result: res_w_q, status: status_w_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== tb/stream_sum_mean_std_test.sv =====
// ----------------------------------------------------------------------------
// stream_sum_mean_std_test
// Self-checking bench for the streaming sum / mean / deviation block.
// A table of directed sample sets covers the reset setup, the numeric
// extremes, every operation, the ddof and overflow status cases and the
// unused operation code. Random runs of one to six sets follow, with the
// setup changed between runs. Each result is checked against the table's
// typed value or else an exact integer model of the statistics. The sender
// idles in random bursts and the receiver stalls in random modes.
// ----------------------------------------------------------------------------
module stream_sum_mean_std_test;
	import ssms_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT    = 4_000_000;
	localparam int RANDOM_SAMPLES = 1400;
	localparam int SETTLE_CYCLES  = 16;
	localparam int DRAIN_CYCLES   = 400;
	localparam int MAX_REPORTS    = 10;
	localparam int PLAN_ROWS      = 15;

	typedef struct packed {
		logic               setup;
		logic [1:0]         op;
		logic [DDOF_W-1:0]  ddof;
		logic [31:0]        len;
		logic signed [15:0] even_val;
		logic signed [15:0] odd_val;
		logic               known;
		out_t               want;
	} set_plan_t;

	logic              clk;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic              cfg_index  = CFG_OPERATION;
	logic [DDOF_W-1:0] cfg_wdata  = '0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	in_t               item       = '0;
	logic              res_valid;
	logic              res_ready  = 1'b0;
	out_t              res;

	// model state
	logic [1:0]              cur_op    = OP_SUM;
	logic [DDOF_W-1:0]       cur_ddof  = '0;
	logic [CNT_W-1:0]        acc_count = '0;
	logic signed [SUM_W-1:0] acc_sum   = '0;
	logic [SQS_W-1:0]        acc_sumsq = '0;
	logic                    acc_ovf   = 1'b0;

	out_t      expected_stats [$];
	out_t      want;
	set_plan_t plan [PLAN_ROWS];

	int     mismatches   = 0;
	int     results_seen = 0;
	int     sets_sent    = 0;
	int     samples_sent = 0;
	int     burst_left   = 0;
	longint cycle_count  = 0;
	logic [5:0] rx_phase = '0;
	logic [1:0] rx_mode  = '0;

	stream_sum_mean_std dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_stats.size());
		$display("FAILED: results differ");
		$finish;
	end

	// Adds one sample to the running totals, or flags overflow once they are full; on last, yields the statistic.
	function automatic logic fold_sample(input in_t s, output out_t r);
		logic signed [31:0] v;
		logic [31:0]        sq;
		logic signed [63:0] sum64, scaled, nl;
		logic [63:0]        n, mag, spread, den;
		logic [127:0]       quot, root, cand;
		int                 b;
		r = '0;
		v = {{16{s.sample[15]}}, s.sample};
		sq = v * v;
		if (acc_count >= MAX_COUNT) begin
			acc_ovf = 1'b1;
		end else begin
			acc_count = acc_count + 1'b1;
			acc_sum = acc_sum + v;
			acc_sumsq = acc_sumsq + sq;
		end
		if (!s.last)
			return 1'b0;
		n = 64'(acc_count);
		nl = 64'(acc_count);
		sum64 = 64'(acc_sum);
		mag = (sum64 < 0) ? -sum64 : sum64;
		if (acc_ovf) begin
			r.status = ST_OVF;
		end else if (n <= cur_ddof) begin
			r.status = ST_DDOF;
		end else begin
			r.status = ST_OK;
			case (cur_op)
				OP_SUM: begin
					r.result = RES_W'(sum64 * 65536);
				end
				OP_MEAN: begin
					scaled = sum64 * 65536;
					if (scaled >= 0)
						r.result = RES_W'(scaled / nl);
					else
						r.result = RES_W'(-((-scaled + nl - 1) / nl));
				end
				OP_STD: begin
					spread = n * acc_sumsq - mag * mag;
					den = n * (n - cur_ddof);
					quot = {spread, 32'd0} / {64'd0, den};
					root = '0;
					for (b = 47; b >= 0; b--) begin
						cand = root | (128'd1 << b);
						if (cand * cand <= quot)
							root = cand;
					end
					r.result = root[RES_W-1:0];
				end
				default: begin
					r.result = '0;
				end
			endcase
		end
		acc_count = '0;
		acc_sum = '0;
		acc_sumsq = '0;
		acc_ovf = 1'b0;
		return 1'b1;
	endfunction

	function automatic set_plan_t plan_set(input logic setup, input logic [1:0] op,
			input logic [DDOF_W-1:0] ddof, input int len,
			input logic signed [15:0] even_val, input logic signed [15:0] odd_val,
			input logic known, input logic signed [RES_W-1:0] result,
			input logic [1:0] status);
		set_plan_t p;
		p.setup = setup;
		p.op = op;
		p.ddof = ddof;
		p.len = len;
		p.even_val = even_val;
		p.odd_val = odd_val;
		p.known = known;
		p.want.result = result;
		p.want.status = status;
		return p;
	endfunction

	// One transfer on the sample channel, with sender idling between bursts.
	task automatic send_item(input logic signed [15:0] v, input logic l,
			input logic known, input out_t typed);
		in_t  it;
		out_t predicted;
		int   gap;
		it.sample = v;
		it.last = l;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		burst_left--;
		samples_sent++;
		if (fold_sample(it, predicted)) begin
			expected_stats.push_back(known ? typed : predicted);
			sets_sent++;
		end
	endtask

	// Drain, then write both registers while the block is idle.
	task automatic reconfigure(input logic [1:0] op, input logic [DDOF_W-1:0] ddof);
		item_valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OPERATION;
		cfg_wdata <= {{(DDOF_W-2){1'b0}}, op};
		@(posedge clk);
		cur_op = op;
		cfg_index <= CFG_DOF;
		cfg_wdata <= ddof;
		@(posedge clk);
		cur_ddof = ddof;
		cfg_we <= 1'b0;
		burst_left = 0;
	endtask

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (expected_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("cycle %0d: unexpected result %0d status %0d",
						cycle_count, res.result, res.status);
			end else begin
				want = expected_stats.pop_front();
				if (res.result !== want.result || res.status !== want.status) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"cycle %0d: expected result %0d status %0d, ",
							"got result %0d status %0d"},
							cycle_count, want.result, want.status, res.result, res.status);
				end
			end
		end
		rx_phase <= rx_phase + 1'b1;
		if (rx_phase == '0)
			rx_mode <= 2'($urandom_range(0, 3));
		case (rx_mode)
			2'd0: res_ready <= 1'b1;
			2'd1: res_ready <= ($urandom_range(0, 3) != 0);
			2'd2: res_ready <= ($urandom_range(0, 1) != 0);
			default: res_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	initial begin
		int                 i, k, len, grp, sel, sent;
		logic [1:0]         op;
		logic [DDOF_W-1:0]  ddof;
		logic signed [15:0] v;

		// first rows run on the reset setup: sum, ddof 0
		plan[0]  = plan_set(1'b0, OP_SUM, 16'd0, 1, 16'sd5, 16'sd5,
			1'b1, 48'sd327680, ST_OK);
		plan[1]  = plan_set(1'b0, OP_SUM, 16'd0, 1, -16'sd32768, -16'sd32768,
			1'b1, -48'sd2147483648, ST_OK);
		plan[2]  = plan_set(1'b0, OP_SUM, 16'd0, 1, 16'sd32767, 16'sd32767,
			1'b1, 48'sd2147418112, ST_OK);
		// mean rounds toward minus infinity
		plan[3]  = plan_set(1'b1, OP_MEAN, 16'd0, 3, -16'sd1, 16'sd0,
			1'b1, -48'sd43691, ST_OK);
		plan[4]  = plan_set(1'b0, OP_MEAN, 16'd0, 2, 16'sd7, 16'sd8,
			1'b1, 48'sd491520, ST_OK);
		plan[5]  = plan_set(1'b1, OP_STD, 16'd0, 2, 16'sd1, -16'sd1,
			1'b1, 48'sd65536, ST_OK);
		plan[6]  = plan_set(1'b0, OP_STD, 16'd0, 1, -16'sd32768, -16'sd32768,
			1'b1, 48'sd0, ST_OK);
		plan[7]  = plan_set(1'b1, OP_STD, 16'd1, 4, 16'sd32767, -16'sd32768,
			1'b0, '0, ST_OK);
		// count not above ddof
		plan[8]  = plan_set(1'b0, OP_STD, 16'd1, 1, 16'sd100, 16'sd100,
			1'b1, 48'sd0, ST_DDOF);
		plan[9]  = plan_set(1'b1, OP_MEAN, 16'd65535, 3, 16'sd4, 16'sd4,
			1'b1, 48'sd0, ST_DDOF);
		plan[10] = plan_set(1'b1, OP_UNUSED, 16'd0, 2, 16'sd9, 16'sd9,
			1'b1, 48'sd0, ST_OK);
		// full-size sets: most negative sum, widest deviation, then overflow
		plan[11] = plan_set(1'b1, OP_SUM, 16'd65535, MAX_COUNT, -16'sd32768, -16'sd32768,
			1'b1, 48'h8000_0000_0000, ST_OK);
		plan[12] = plan_set(1'b1, OP_STD, 16'd65535, MAX_COUNT, -16'sd32768, 16'sd32767,
			1'b0, '0, ST_OK);
		plan[13] = plan_set(1'b1, OP_MEAN, 16'd0, MAX_COUNT + 1, 16'sd32767, 16'sd32767,
			1'b1, 48'sd0, ST_OVF);
		plan[14] = plan_set(1'b0, OP_MEAN, 16'd0, 1, 16'sd0, 16'sd0,
			1'b1, 48'sd0, ST_OK);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].setup)
				reconfigure(plan[i].op, plan[i].ddof);
			for (k = 0; k < int'(plan[i].len); k++)
				send_item((k % 2 == 1) ? plan[i].odd_val : plan[i].even_val,
					k == int'(plan[i].len) - 1, plan[i].known, plan[i].want);
		end

		sent = 0;
		while (sent < RANDOM_SAMPLES) begin
			sel = $urandom_range(0, 9);
			op = (sel < 3) ? OP_SUM : (sel < 6) ? OP_MEAN : (sel < 9) ? OP_STD : OP_UNUSED;
			sel = $urandom_range(0, 9);
			if (sel < 5)
				ddof = '0;
			else if (sel < 7)
				ddof = DDOF_W'($urandom_range(1, 3));
			else if (sel < 8)
				ddof = DDOF_W'($urandom_range(0, 40));
			else if (sel < 9)
				ddof = 16'hFFFF;
			else
				ddof = DDOF_W'($urandom_range(0, 65535));
			reconfigure(op, ddof);
			for (grp = $urandom_range(1, 6); grp > 0; grp--) begin
				sel = $urandom_range(0, 19);
				if (sel < 15)
					len = $urandom_range(1, 12);
				else if (sel < 19)
					len = $urandom_range(13, 64);
				else
					len = $urandom_range(100, 250);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 7))
						0: v = -16'sd32768;
						1: v = 16'sd32767;
						2: v = 16'($urandom_range(0, 15) - 8);
						3: v = -16'sd1;
						default: v = 16'($urandom());
					endcase
					send_item(v, k == len - 1, 1'b0, '0);
				end
				sent += len;
			end
		end

		item_valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("streamed %0d samples in %0d sets, checked %0d results, %0d mismatches",
			samples_sent, sets_sent, results_seen, mismatches);
		$display({"setups: sum, mean, deviation and the unused code; ",
			"ddof 0 to 65535; sets of 1 to 65537 samples"});
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
